### rtl/tmsws_pkg.sv
// shared codes and constants for the tile map store with window scroll
package tmsws_pkg;

  localparam int CoordW = 7;
  localparam int ShiftW = 8;
  localparam int SizeW  = 7;
  localparam int KindW  = 2;
  localparam int StatW  = 2;
  localparam int CmdW   = 2;
  localparam int WrapW  = 2;
  localparam int CfgIdxW = 1;
  localparam int CoordMax = (1 << CoordW) - 1;

  typedef enum logic [CmdW-1:0] {
    CMD_SET    = 2'd0,
    CMD_GET    = 2'd1,
    CMD_SCROLL = 2'd2
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    STS_DONE    = 2'd0,
    STS_OUTSIDE = 2'd1,
    STS_REJECT  = 2'd2
  } status_e;

  typedef enum logic [KindW-1:0] {
    KIND_EMPTY   = 2'd0,
    KIND_DIRECT  = 2'd1,
    KIND_INDEXED = 2'd2
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MAP_COLUMNS = 1'b0,
    REG_MAP_ROWS    = 1'b1
  } reg_e;

endpackage

### rtl/tile_map_store_with_window_scroll.sv
// top level: tile map store with set, get and windowed scroll
//
// channel   direction  handshake                      payload
// s_axis    in         s_axis_tvalid / s_axis_tready  tuser {entry_kind, cmd}, tdata fields
// m_axis    out        m_axis_tvalid / m_axis_tready  tuser cell_kind, tdata fields
// cfg       in         cfg_we_i                       cfg_idx_i, cfg_wdata_i
//
// after reset a clearing pass writes every tile entry empty
// scroll: the circular offsets are reduced first, then the window is copied to scratch
// and written back from it, one cell per cycle per memory port
// one transaction in work at a time; a new one is taken while the last result waits
// a stalled result holds the finished transaction until the output register frees
module tile_map_store_with_window_scroll #(
  parameter int MAX_COLUMNS = 64,
  parameter int MAX_ROWS    = 64,
  parameter int HANDLE_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  // x, y, bitmap_ref, palette_ref, shift_x, shift_y, win_w, win_h, wrap_mode
  input  logic [((46 + 2 * HANDLE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // cmd, entry_kind
  input  logic [2 * tmsws_pkg::KindW - 1:0] s_axis_tuser,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // status, cell_bitmap, cell_palette
  output logic [((2 + 2 * HANDLE_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
  // cell_kind
  output logic [tmsws_pkg::KindW-1:0] m_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  input  logic cfg_we_i,
  input  logic [tmsws_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [tmsws_pkg::SizeW-1:0] cfg_wdata_i
);
  import tmsws_pkg::*;

  localparam int H       = HANDLE_BITS;
  localparam int Depth   = MAX_COLUMNS * MAX_ROWS;
  localparam int AW      = Depth > 1 ? $clog2(Depth) : 1;
  localparam int CellW   = KindW + 2 * H;
  localparam int OutDataW = ((2 + 2 * H + 7) / 8) * 8;
  localparam int OffY    = CoordW;
  localparam int OffBmp  = 2 * CoordW;
  localparam int OffPal  = OffBmp + H;
  localparam int OffSx   = OffPal + H;
  localparam int OffSy   = OffSx + ShiftW;
  localparam int OffW    = OffSy + ShiftW;
  localparam int OffH    = OffW + SizeW;
  localparam int OffWrap = OffH + SizeW;
  localparam int RelW    = 10;
  localparam logic [SizeW-1:0] ColLim =
    SizeW'(MAX_COLUMNS > CoordMax ? CoordMax : MAX_COLUMNS);
  localparam logic [SizeW-1:0] RowLim =
    SizeW'(MAX_ROWS > CoordMax ? CoordMax : MAX_ROWS);
  localparam logic [SizeW-1:0] ResetSize = SizeW'(64);
  localparam logic [AW-1:0] LastAddr = AW'(Depth - 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_GET_WAIT, S_MOD, S_COPY, S_COPY_DRAIN,
    S_MOVE, S_MOVE_DRAIN, S_FINISH
  } state_e;

  function automatic logic [SizeW-1:0] clamp_size(input logic [SizeW-1:0] v,
                                                  input logic [SizeW-1:0] lim);
    logic [SizeW-1:0] s;
    s = (v == '0) ? SizeW'(1) : v;
    if (s > lim) s = lim;
    return s;
  endfunction

  function automatic logic [AW-1:0] cell_addr(input logic [CoordW-1:0] row,
                                              input logic [CoordW-1:0] col);
    return AW'(32'(row) * MAX_COLUMNS + 32'(col));
  endfunction

  logic [SizeW-1:0] cols_q, rows_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= clamp_size(ResetSize, ColLim);
      rows_q <= clamp_size(ResetSize, RowLim);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MAP_COLUMNS: cols_q <= clamp_size(cfg_wdata_i, ColLim);
        REG_MAP_ROWS:    rows_q <= clamp_size(cfg_wdata_i, RowLim);
        default: ;
      endcase
    end
  end

  state_e state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [CmdW-1:0] cmd_q, cmd_d;
  logic [KindW-1:0] kind_q, kind_d;
  logic [CoordW-1:0] x_q, x_d, y_q, y_d, i_q, i_d, j_q, j_d;
  logic [H-1:0] bmp_q, bmp_d, pal_q, pal_d;
  logic signed [ShiftW-1:0] sx_q, sx_d, sy_q, sy_d;
  logic [SizeW-1:0] w_q, w_d, h_q, h_d;
  logic [WrapW-1:0] wrap_q, wrap_d;
  logic signed [RelW-1:0] rx_q, rx_d, ry_q, ry_d, rx0_q, rx0_d;
  logic pv_q, pv_d, mv_q, mv_d, min_q, min_d;
  logic [AW-1:0] pa_q, pa_d, ma_q, ma_d;
  logic [StatW-1:0] rs_status_q, rs_status_d, m_status_q, m_status_d;
  logic [KindW-1:0] rs_kind_q, rs_kind_d, m_kind_q, m_kind_d;
  logic [H-1:0] rs_bmp_q, rs_bmp_d, rs_pal_q, rs_pal_d;
  logic [H-1:0] m_bmp_q, m_bmp_d, m_pal_q, m_pal_d;
  logic m_valid_q, m_valid_d;

  logic tile_we, tile_re, scr_we, scr_re;
  logic [AW-1:0] tile_waddr, tile_raddr, scr_waddr, scr_raddr;
  logic [CellW-1:0] tile_wdata, tile_rdata, scr_rdata;

  logic out_free, in_map, fits, in_x, in_y, adj_x, adj_y;
  logic signed [RelW-1:0] wsz, hsz, rx_n, ry_n;
  logic [CoordW:0] x_end, y_end;

  assign s_axis_tready = (state_q == S_IDLE);
  assign out_free = !m_valid_q || m_axis_tready;
  assign wsz = $signed(RelW'(w_q));
  assign hsz = $signed(RelW'(h_q));
  assign in_map = (x_q < cols_q) && (y_q < rows_q);
  assign x_end = {1'b0, x_q} + {1'b0, w_q};
  assign y_end = {1'b0, y_q} + {1'b0, h_q};
  assign fits = (x_end <= {1'b0, cols_q}) && (y_end <= {1'b0, rows_q});
  assign in_x = !rx_q[RelW-1] && (rx_q < wsz);
  assign in_y = !ry_q[RelW-1] && (ry_q < hsz);
  assign adj_x = wrap_q[0] && (rx_q[RelW-1] || rx_q >= wsz);
  assign adj_y = wrap_q[1] && (ry_q[RelW-1] || ry_q >= hsz);
  assign rx_n = (wrap_q[0] && (rx_q + RelW'(1) == wsz)) ? '0 : rx_q + RelW'(1);
  assign ry_n = (wrap_q[1] && (ry_q + RelW'(1) == hsz)) ? '0 : ry_q + RelW'(1);

  always_comb begin
    state_d = state_q;
    clr_d = clr_q;
    cmd_d = cmd_q; kind_d = kind_q; x_d = x_q; y_d = y_q;
    bmp_d = bmp_q; pal_d = pal_q; sx_d = sx_q; sy_d = sy_q;
    w_d = w_q; h_d = h_q; wrap_d = wrap_q;
    i_d = i_q; j_d = j_q; rx_d = rx_q; ry_d = ry_q; rx0_d = rx0_q;
    pv_d = 1'b0; pa_d = pa_q; mv_d = 1'b0; ma_d = ma_q; min_d = min_q;
    rs_status_d = rs_status_q; rs_kind_d = rs_kind_q;
    rs_bmp_d = rs_bmp_q; rs_pal_d = rs_pal_q;
    m_status_d = m_status_q; m_kind_d = m_kind_q;
    m_bmp_d = m_bmp_q; m_pal_d = m_pal_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    tile_we = 1'b0; tile_waddr = '0; tile_wdata = '0;
    tile_re = 1'b0; tile_raddr = '0;
    scr_re = 1'b0; scr_raddr = '0;

    unique case (state_q)
      S_CLEAR: begin
        tile_we = 1'b1;
        tile_waddr = clr_q;
        clr_d = clr_q + AW'(1);
        if (clr_q == LastAddr) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_d  = s_axis_tuser[CmdW-1:0];
          kind_d = s_axis_tuser[CmdW +: KindW];
          x_d    = s_axis_tdata[CoordW-1:0];
          y_d    = s_axis_tdata[OffY +: CoordW];
          bmp_d  = s_axis_tdata[OffBmp +: H];
          pal_d  = s_axis_tdata[OffPal +: H];
          sx_d   = $signed(s_axis_tdata[OffSx +: ShiftW]);
          sy_d   = $signed(s_axis_tdata[OffSy +: ShiftW]);
          w_d    = s_axis_tdata[OffW +: SizeW];
          h_d    = s_axis_tdata[OffH +: SizeW];
          wrap_d = s_axis_tdata[OffWrap +: WrapW];
          rs_status_d = STS_DONE;
          rs_kind_d = KIND_EMPTY;
          rs_bmp_d = '0;
          rs_pal_d = '0;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_FINISH;
        case (cmd_q)
          CMD_SET: begin
            if (!in_map) begin
              rs_status_d = STS_OUTSIDE;
            end else begin
              tile_we = 1'b1;
              tile_waddr = cell_addr(y_q, x_q);
              case (kind_q)
                KIND_DIRECT:  tile_wdata = {{H{1'b0}}, bmp_q, KIND_DIRECT};
                KIND_INDEXED: tile_wdata = {pal_q, bmp_q, KIND_INDEXED};
                default:      tile_wdata = '0;
              endcase
            end
          end
          CMD_GET: begin
            if (!in_map) begin
              rs_status_d = STS_OUTSIDE;
            end else begin
              tile_re = 1'b1;
              tile_raddr = cell_addr(y_q, x_q);
              state_d = S_GET_WAIT;
            end
          end
          CMD_SCROLL: begin
            if (!fits) begin
              rs_status_d = STS_REJECT;
            end else if ((sx_q != '0 || sy_q != '0) && w_q != '0 && h_q != '0) begin
              rx_d = RelW'(sx_q);
              ry_d = RelW'(sy_q);
              state_d = S_MOD;
            end
          end
          default: ;
        endcase
      end
      S_GET_WAIT: begin
        rs_kind_d = tile_rdata[KindW-1:0];
        rs_bmp_d  = tile_rdata[KindW +: H];
        rs_pal_d  = tile_rdata[KindW + H +: H];
        state_d = S_FINISH;
      end
      S_MOD: begin
        if (adj_x) rx_d = rx_q[RelW-1] ? rx_q + wsz : rx_q - wsz;
        if (adj_y) ry_d = ry_q[RelW-1] ? ry_q + hsz : ry_q - hsz;
        if (!adj_x && !adj_y) begin
          rx0_d = rx_q;
          i_d = '0;
          j_d = '0;
          state_d = S_COPY;
        end
      end
      S_COPY: begin
        tile_re = 1'b1;
        tile_raddr = cell_addr(y_q + j_q, x_q + i_q);
        pv_d = 1'b1;
        pa_d = tile_raddr;
        if (i_q == w_q - SizeW'(1)) begin
          i_d = '0;
          if (j_q == h_q - SizeW'(1)) begin
            j_d = '0;
            state_d = S_COPY_DRAIN;
          end else begin
            j_d = j_q + CoordW'(1);
          end
        end else begin
          i_d = i_q + CoordW'(1);
        end
      end
      S_COPY_DRAIN: begin
        state_d = S_MOVE;
      end
      S_MOVE: begin
        scr_re = in_x && in_y;
        scr_raddr = cell_addr(y_q + ry_q[CoordW-1:0], x_q + rx_q[CoordW-1:0]);
        mv_d = 1'b1;
        min_d = in_x && in_y;
        ma_d = cell_addr(y_q + j_q, x_q + i_q);
        if (i_q == w_q - SizeW'(1)) begin
          i_d = '0;
          rx_d = rx0_q;
          ry_d = ry_n;
          if (j_q == h_q - SizeW'(1)) begin
            state_d = S_MOVE_DRAIN;
          end else begin
            j_d = j_q + CoordW'(1);
          end
        end else begin
          i_d = i_q + CoordW'(1);
          rx_d = rx_n;
        end
      end
      S_MOVE_DRAIN: begin
        state_d = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_status_d = rs_status_q;
          m_kind_d = rs_kind_q;
          m_bmp_d = rs_bmp_q;
          m_pal_d = rs_pal_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (mv_q) begin
      tile_we = 1'b1;
      tile_waddr = ma_q;
      tile_wdata = min_q ? scr_rdata : '0;
    end
  end

  assign scr_we = pv_q;
  assign scr_waddr = pa_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q <= '0;
      cmd_q <= '0; kind_q <= '0; x_q <= '0; y_q <= '0;
      bmp_q <= '0; pal_q <= '0; sx_q <= '0; sy_q <= '0;
      w_q <= '0; h_q <= '0; wrap_q <= '0;
      i_q <= '0; j_q <= '0; rx_q <= '0; ry_q <= '0; rx0_q <= '0;
      pv_q <= 1'b0; pa_q <= '0; mv_q <= 1'b0; ma_q <= '0; min_q <= 1'b0;
      rs_status_q <= '0; rs_kind_q <= '0; rs_bmp_q <= '0; rs_pal_q <= '0;
      m_status_q <= '0; m_kind_q <= '0; m_bmp_q <= '0; m_pal_q <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      cmd_q <= cmd_d; kind_q <= kind_d; x_q <= x_d; y_q <= y_d;
      bmp_q <= bmp_d; pal_q <= pal_d; sx_q <= sx_d; sy_q <= sy_d;
      w_q <= w_d; h_q <= h_d; wrap_q <= wrap_d;
      i_q <= i_d; j_q <= j_d; rx_q <= rx_d; ry_q <= ry_d; rx0_q <= rx0_d;
      pv_q <= pv_d; pa_q <= pa_d; mv_q <= mv_d; ma_q <= ma_d; min_q <= min_d;
      rs_status_q <= rs_status_d; rs_kind_q <= rs_kind_d;
      rs_bmp_q <= rs_bmp_d; rs_pal_q <= rs_pal_d;
      m_status_q <= m_status_d; m_kind_q <= m_kind_d;
      m_bmp_q <= m_bmp_d; m_pal_q <= m_pal_d;
      m_valid_q <= m_valid_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_kind_q;
  assign m_axis_tdata  = OutDataW'({m_pal_q, m_bmp_q, m_status_q});

  tmsws_ram #(
    .WIDTH(CellW),
    .DEPTH(Depth)
  ) u_tile_ram (
    .clk_i  (clk_i),
    .we_i   (tile_we),
    .waddr_i(tile_waddr),
    .wdata_i(tile_wdata),
    .re_i   (tile_re),
    .raddr_i(tile_raddr),
    .rdata_o(tile_rdata)
  );

  tmsws_ram #(
    .WIDTH(CellW),
    .DEPTH(Depth)
  ) u_scratch_ram (
    .clk_i  (clk_i),
    .we_i   (scr_we),
    .waddr_i(scr_waddr),
    .wdata_i(tile_rdata),
    .re_i   (scr_re),
    .raddr_i(scr_raddr),
    .rdata_o(scr_rdata)
  );

`ifndef SYNTHESIS
  a_no_accept_during_tile_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tile_we |-> !s_axis_tready)
    else $error("input taken while tile store is written");

  a_fail_has_no_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[StatW-1:0] != STS_DONE) |->
      (m_axis_tuser == KIND_EMPTY && m_axis_tdata[StatW +: 2 * H] == '0))
    else $error("failed transaction carries cell data");

  a_scratch_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (scr_we && scr_re) |-> (scr_waddr != scr_raddr))
    else $error("scratch read and write hit one entry");

  a_move_write_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mv_q |-> $past(state_q == S_MOVE))
    else $error("write-back without a move step");
`endif

endmodule

### rtl/tmsws_ram.sv
// generic simple dual-port ram with registered read
module tmsws_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 4096
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
